/* hw/rtl/bb3_pkg.sv */
`default_nettype none
package bb3_pkg;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam int MIN_DIM = 3;
    localparam int DIVISOR = 9;
    localparam int Q_DEPTH = 8;

    typedef struct packed {
        logic valid;
        logic emit;
        logic border;
        logic last;
    } t_stage_ctl;

endpackage
`default_nettype wire

/* hw/rtl/bb3_out_fifo.sv */
`default_nettype none
module bb3_out_fifo #(
    parameter int DATA_W = 9
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic [DATA_W-1:0]                      i_push_data,
    input  logic                                   i_pop,
    output logic                                   o_valid,
    output logic [DATA_W-1:0]                      o_data,
    output logic [$clog2(bb3_pkg::Q_DEPTH+1)-1:0]  o_count
);

    localparam int PTR_W = $clog2(bb3_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(bb3_pkg::Q_DEPTH+1);

    logic [DATA_W-1:0] r_mem [bb3_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10: n_count = r_count + CNT_W'(1);
            2'b01: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

/* hw/rtl/box_blur_3x3_stream.sv */
`default_nettype none
// 3x3 box blur on a raster stream of grey pixels: one request per clock is taken
// and one result per clock delivered when the sink keeps up. Each pixel or drain
// request reads both line store banks; a pixel request writes one at the current
// column, so the single write port of each bank sets the rate at one request per
// cycle. A result passes bank read, window shift, window sum and divide by nine, in
// that order, after the request that completes it, that request coming one row
// plus one pixel after the pixel itself. Border pixels pass through unchanged.
// After the last pixel of an image, drain requests (flush or pixel, the pixel
// being dropped) push out the remaining w+1 results; the last one carries
// o_last_pixel. An 8-entry output queue holds results while the sink stalls;
// o_in_ready drops only when that queue and the results in flight could fill it.
// The line store is not cleared after reset: it needs no clearing pass. A write
// to image_width or image_height restarts the frame and must be made while idle.
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [PIXEL_BITS-1:0]                i_pixel_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [PIXEL_BITS-1:0]                o_pixel_out,
    output logic                                 o_last_pixel,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bb3_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [bb3_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [bb3_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int WX    = (CW > bb3_pkg::CFG_WIDTH_BITS) ? CW : bb3_pkg::CFG_WIDTH_BITS;
    localparam int HX    = (RW > bb3_pkg::CFG_HEIGHT_BITS) ? RW : bb3_pkg::CFG_HEIGHT_BITS;
    localparam int SUM_W = PIXEL_BITS + 4;
    localparam int RK    = SUM_W + 3;
    localparam int MW    = RK - 3;
    localparam int PW_   = SUM_W + MW;
    localparam logic [MW-1:0] RECIP = MW'(((2 ** RK) + bb3_pkg::DIVISOR - 1) / bb3_pkg::DIVISOR);
    localparam int QCW   = $clog2(bb3_pkg::Q_DEPTH + 1);
    localparam int PCW   = $clog2(bb3_pkg::Q_DEPTH + 4);

    // configuration
    logic [bb3_pkg::CFG_WIDTH_BITS-1:0]  r_cfg_width;
    logic [bb3_pkg::CFG_HEIGHT_BITS-1:0] r_cfg_height;
    logic                                cfg_wr;
    logic [WX-1:0]                       w_raw;
    logic [HX-1:0]                       h_raw;
    logic [CW-1:0]                       w_eff;
    logic [RW-1:0]                       h_eff;

    // positions
    logic [CW-1:0] r_in_col;
    logic [CW-1:0] n_in_col;
    logic [RW-1:0] r_in_row;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] r_out_col;
    logic [CW-1:0] n_out_col;
    logic [RW-1:0] r_out_row;
    logic [RW-1:0] n_out_row;

    logic                  acc;
    logic                  drain;
    logic                  step;
    logic                  emit;
    logic                  out_last;
    logic                  border;
    logic [PIXEL_BITS-1:0] pix;

    // line store
    logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];
    logic [AW-1:0]         mem_addr;
    logic                  we_a;
    logic                  we_b;
    logic [PIXEL_BITS-1:0] r_rd_a;
    logic [PIXEL_BITS-1:0] r_rd_b;

    // pipeline
    bb3_pkg::t_stage_ctl   r_s1;
    bb3_pkg::t_stage_ctl   r_s2;
    bb3_pkg::t_stage_ctl   r_s3;
    logic                  r_s1_slot;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic [PIXEL_BITS-1:0] win_top;
    logic [PIXEL_BITS-1:0] win_mid;
    logic [SUM_W-1:0]      row_sum [3];
    logic [SUM_W-1:0]      win_sum;
    logic [SUM_W-1:0]      r_s3_sum;
    logic [PIXEL_BITS-1:0] r_s3_center;
    logic [PW_-1:0]        prod;
    logic [PIXEL_BITS-1:0] result_pix;

    // output queue
    logic                  q_push;
    logic                  q_pop;
    logic [PIXEL_BITS:0]   q_push_data;
    logic [PIXEL_BITS:0]   q_data;
    logic [QCW-1:0]        q_count;
    logic [PCW-1:0]        pending;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bb3_pkg::WIDTH_RESET;
            r_cfg_height <= bb3_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == bb3_pkg::REG_HEIGHT) begin
                r_cfg_height <= pwdata[bb3_pkg::CFG_HEIGHT_BITS-1:0];
            end else begin
                r_cfg_width <= pwdata[bb3_pkg::CFG_WIDTH_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == bb3_pkg::REG_HEIGHT) ?
                    bb3_pkg::APB_DATA_BITS'(r_cfg_height) :
                    bb3_pkg::APB_DATA_BITS'(r_cfg_width);

    assign w_raw = WX'(r_cfg_width);
    assign h_raw = HX'(r_cfg_height);
    assign w_eff = (w_raw < WX'(bb3_pkg::MIN_DIM)) ? CW'(bb3_pkg::MIN_DIM) :
                   (w_raw > WX'(MAX_WIDTH))        ? CW'(MAX_WIDTH)        : CW'(w_raw);
    assign h_eff = (h_raw < HX'(bb3_pkg::MIN_DIM)) ? RW'(bb3_pkg::MIN_DIM) :
                   (h_raw > HX'(MAX_HEIGHT))       ? RW'(MAX_HEIGHT)       : RW'(h_raw);

    // request decode
    assign acc      = i_in_valid && o_in_ready;
    assign drain    = (r_in_row >= h_eff);
    assign step     = acc && ((i_operation == bb3_pkg::OP_PIXEL) || drain);
    assign pix      = drain ? '0 : i_pixel_in;
    assign emit     = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign out_last = (r_out_row >= h_eff - RW'(1)) && (r_out_col >= w_eff - CW'(1));
    assign border   = (r_out_row == '0) || (r_out_row >= h_eff - RW'(1)) ||
                      (r_out_col == '0) || (r_out_col >= w_eff - CW'(1));

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (step) begin
            if (r_in_col >= w_eff - CW'(1)) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (out_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (r_out_col >= w_eff - CW'(1)) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // line store, bank chosen by row parity
    assign mem_addr = r_in_col[AW-1:0];
    assign we_a     = step && !drain && !r_in_row[0];
    assign we_b     = step && !drain && r_in_row[0];

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd_a <= mem_a[mem_addr];
        end
        if (we_a) begin
            mem_a[mem_addr] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd_b <= mem_b[mem_addr];
        end
        if (we_b) begin
            mem_b[mem_addr] <= pix;
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1.valid  <= step;
            r_s1.emit   <= emit;
            r_s1.border <= border;
            r_s1.last   <= out_last;
            r_s2.valid  <= r_s1.valid && r_s1.emit;
            r_s2.emit   <= 1'b1;
            r_s2.border <= r_s1.border;
            r_s2.last   <= r_s1.last;
            r_s3        <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_slot <= r_in_row[0];
        r_s1_pix  <= pix;
    end

    // window shift
    assign win_top = r_s1_slot ? r_rd_b : r_rd_a;
    assign win_mid = r_s1_slot ? r_rd_a : r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (r_s1.valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= win_top;
            r_win[1][2] <= win_mid;
            r_win[2][2] <= r_s1_pix;
        end
    end

    // window sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = SUM_W'(r_win[r][0]) + SUM_W'(r_win[r][1]) + SUM_W'(r_win[r][2]);
        end
        win_sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge i_clk) begin
        r_s3_sum    <= win_sum;
        r_s3_center <= r_win[1][1];
    end

    // divide by nine through the reciprocal
    assign prod        = PW_'(r_s3_sum) * PW_'(RECIP);
    assign result_pix  = r_s3.border ? r_s3_center : prod[RK +: PIXEL_BITS];
    assign q_push      = r_s3.valid;
    assign q_push_data = {r_s3.last, result_pix};
    assign q_pop       = o_out_valid && i_out_ready;

    bb3_out_fifo #(
        .DATA_W (PIXEL_BITS + 1)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_valid     (o_out_valid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    assign o_pixel_out  = q_data[PIXEL_BITS-1:0];
    assign o_last_pixel = q_data[PIXEL_BITS];

    // room for every result already on its way
    assign pending    = PCW'(q_count) + PCW'(r_s1.valid && r_s1.emit) +
                        PCW'(r_s2.valid) + PCW'(r_s3.valid);
    assign o_in_ready = (pending < PCW'(bb3_pkg::Q_DEPTH));

`ifndef SYNTH
    a_queue_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> ((q_count != QCW'(bb3_pkg::Q_DEPTH)) || q_pop))
        else $error("output queue overflow");

    a_col_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col < w_eff) && (r_out_col < w_eff))
        else $error("column counter beyond image width");

    a_last_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit && out_last && !cfg_wr) |=>
        ((r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0)))
        else $error("frame did not restart after last pixel");
`endif

endmodule
`default_nettype wire

/* tb/box_blur_3x3_stream_tb.sv */
`timescale 1ns / 100ps

module box_blur_3x3_stream_tb;

    localparam int PIX_BITS      = 8;
    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int RANDOM_ITEMS  = 640;
    localparam int SETTLE_CYCLES = 16;
    localparam int SINK_HOLD     = 300;
    localparam int STALL_LIMIT   = 3000;

    // 4x4 frame: stray flush, saturated and zero pixels, mixed drain, stray flush, new frame
    localparam logic [23:0][8:0] DIRECTED_SEQ = {
        {bb3_pkg::OP_FLUSH, 8'h5A},
        {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'hFF},
        {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'hFF},
        {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'h00}, {bb3_pkg::OP_PIXEL, 8'hFF},
        {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'hFF}, {bb3_pkg::OP_PIXEL, 8'h00},
        {bb3_pkg::OP_PIXEL, 8'h00}, {bb3_pkg::OP_PIXEL, 8'h00}, {bb3_pkg::OP_PIXEL, 8'h00},
        {bb3_pkg::OP_PIXEL, 8'h01},
        {bb3_pkg::OP_FLUSH, 8'h00}, {bb3_pkg::OP_PIXEL, 8'hAA}, {bb3_pkg::OP_FLUSH, 8'hFF},
        {bb3_pkg::OP_FLUSH, 8'h00},
        {bb3_pkg::OP_PIXEL, 8'h55},
        {bb3_pkg::OP_FLUSH, 8'h00},
        {bb3_pkg::OP_PIXEL, 8'h80}
    };

    typedef struct packed {
        logic [PIX_BITS-1:0] value;
        logic                last;
    } t_blur_pixel;

    class blur_checker;
        logic [bb3_pkg::CFG_WIDTH_BITS-1:0]  width_reg;
        logic [bb3_pkg::CFG_HEIGHT_BITS-1:0] height_reg;
        logic [PIX_BITS-1:0]                 line_mem [2][MAX_W];
        logic [PIX_BITS-1:0]                 win [3][3];
        int unsigned                         in_col, in_row, out_col, out_row;
        t_blur_pixel                         blurred_q [$];
        int                                  mismatches;

        function new();
            width_reg  = bb3_pkg::WIDTH_RESET;
            height_reg = bb3_pkg::HEIGHT_RESET;
            for (int s = 0; s < 2; s++)
                for (int c = 0; c < MAX_W; c++)
                    line_mem[s][c] = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    win[r][k] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < bb3_pkg::MIN_DIM) return bb3_pkg::MIN_DIM;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg, MAX_W);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg, MAX_H);
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction

        function void set_register(logic idx, logic [bb3_pkg::APB_DATA_BITS-1:0] value);
            if (idx == bb3_pkg::REG_WIDTH) begin
                width_reg = value[bb3_pkg::CFG_WIDTH_BITS-1:0];
            end else begin
                height_reg = value[bb3_pkg::CFG_HEIGHT_BITS-1:0];
            end
            restart();
        endfunction

        function void absorb_request(logic op, logic [PIX_BITS-1:0] pix);
            int unsigned         w, h, sum, slot;
            logic [PIX_BITS-1:0] fresh;
            logic                drain, emit;
            t_blur_pixel         res;
            w = eff_width();
            h = eff_height();
            drain = (in_row >= h);
            if (op == bb3_pkg::OP_FLUSH && !drain) return;
            fresh = drain ? '0 : pix;
            slot = in_row % 2;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = line_mem[slot][in_col];
            win[1][2] = line_mem[1 - slot][in_col];
            win[2][2] = fresh;
            if (!drain) line_mem[slot][in_col] = fresh;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (!emit) return;
            if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1) begin
                res.value = win[1][1];
            end else begin
                sum = 0;
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        sum += win[r][k];
                res.value = PIX_BITS'(sum / bb3_pkg::DIVISOR);
            end
            res.last = (out_row >= h - 1) && (out_col >= w - 1);
            if (res.last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
            blurred_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_pixel(logic [PIX_BITS-1:0] value, logic last);
            t_blur_pixel want;
            if (blurred_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d last %0b", value, last));
                return;
            end
            want = blurred_q.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("pixel_out %0d, expected %0d", value, want.value));
            if (last !== want.last)
                report_mismatch($sformatf("last_pixel %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic                               i_clk     = 1'b0;
    logic                               i_rst_n   = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               operation = bb3_pkg::OP_PIXEL;
    logic [PIX_BITS-1:0]                pixel_in  = '0;
    logic                               out_ready = 1'b0;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [bb3_pkg::APB_ADDR_BITS-1:0]  paddr     = '0;
    logic [bb3_pkg::APB_DATA_BITS-1:0]  pwdata    = '0;
    wire  [bb3_pkg::APB_DATA_BITS-1:0]  prdata;
    wire                                pready;
    wire                                o_in_ready;
    wire                                o_out_valid;
    wire  [PIX_BITS-1:0]                o_pixel_out;
    wire                                o_last_pixel;

    blur_checker blur_check;
    bit          src_calm  = 1'b0;
    bit          sink_calm = 1'b0;
    bit          hold_sink = 1'b0;
    int unsigned quiet_cycles = 0;

    box_blur_3x3_stream dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (operation),
        .i_pixel_in   (pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) blur_check.absorb_request(operation, pixel_in);
            if (o_out_valid && out_ready) blur_check.check_pixel(o_pixel_out, o_last_pixel);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : sink_pacing
        int stall;
        int turns;
        turns = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                out_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            turns++;
            if (turns % 150 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            stall = pick_gap(sink_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_request(input logic op, input logic [PIX_BITS-1:0] pix);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        pixel_in  <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_pixels(input int unsigned count, input bit noisy);
        for (int unsigned n = 0; n < count; n++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(bb3_pkg::OP_FLUSH, PIX_BITS'($urandom_range(0, 255)));
            send_request(bb3_pkg::OP_PIXEL, PIX_BITS'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_frame(input int unsigned w);
        repeat (w + 1)
            send_request($urandom_range(0, 1) ? bb3_pkg::OP_FLUSH : bb3_pkg::OP_PIXEL,
                         PIX_BITS'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (blur_check.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [bb3_pkg::APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        blur_check.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
        settle();
        write_reg(bb3_pkg::REG_WIDTH, w_raw);
        write_reg(bb3_pkg::REG_HEIGHT, h_raw);
    endtask

    initial begin : stimulus
        int unsigned w, h, sent, cut, roll;
        bit          first, need_restart;
        blur_check = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-width rows first, cut short by the next register write
        set_frame(2047, 0);
        send_pixels(MAX_W + 64, 1'b0);

        set_frame(4, 4);
        for (int i = 23; i >= 0; i--)
            send_request(DIRECTED_SEQ[i][8], DIRECTED_SEQ[i][7:0]);

        // tallest frame at narrowest width, cut short by the next register write
        set_frame(1, 8191);
        send_pixels(30 * bb3_pkg::MIN_DIM, 1'b1);

        sent = 0;
        first = 1'b1;
        need_restart = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (first) begin
                set_frame(32, 4);
                hold_sink = 1'b1;
                src_calm = 1'b1;
            end else begin
                if (need_restart || $urandom_range(0, 4) != 0) begin
                    roll = $urandom_range(0, 99);
                    w = (roll < 10) ? $urandom_range(0, 2) :
                        (roll < 85) ? $urandom_range(3, 16) : $urandom_range(17, 48);
                    roll = $urandom_range(0, 99);
                    h = (roll < 10) ? $urandom_range(0, 2) :
                        (roll < 90) ? $urandom_range(3, 8) : $urandom_range(9, 16);
                    set_frame(w, h);
                end
                src_calm = ($urandom_range(0, 3) == 0);
            end
            need_restart = 1'b0;
            w = blur_check.eff_width();
            h = blur_check.eff_height();
            if (!first && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, w * h - 1);
                send_pixels(cut, 1'b1);
                sent += cut;
                need_restart = 1'b1;
            end else begin
                send_pixels(w * h, 1'b1);
                drain_frame(w);
                sent += w * h + w + 1;
                if ($urandom_range(0, 3) == 0)
                    send_request(bb3_pkg::OP_FLUSH, PIX_BITS'($urandom_range(0, 255)));
            end
            first = 1'b0;
        end

        settle();
        if (blur_check.mismatches == 0 && blur_check.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
